### rtl/iso2ep_pkg.sv
// ============================================================================
// iso2ep_pkg - shared types and constants for the timestamp-to-epoch block
// Character codes, zone and status codes, the stage hand-over struct and the
// calendar constants used by the scanner and the arithmetic pipeline.
// ============================================================================
package iso2ep_pkg;

  // Text layout.
  localparam int unsigned DATE_LEN  = 19;
  localparam int unsigned ZONE_FULL = 5;

  // Character codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UTC   = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Field limits.
  localparam int unsigned MIN_YEAR   = 1970;
  localparam int unsigned MAX_MONTH  = 12;
  localparam int unsigned MAX_DAY    = 31;
  localparam int unsigned MAX_HOUR   = 23;
  localparam int unsigned MAX_MINUTE = 59;
  localparam int unsigned MAX_SECOND = 60;

  // Calendar arithmetic. Division by 400 and by 100 is done by reciprocal
  // multiplication; both are exact over the ranges that reach them.
  localparam int unsigned ERA_RECIP        = 5243;
  localparam int unsigned ERA_SHIFT        = 21;
  localparam int unsigned CENT_RECIP       = 41;
  localparam int unsigned CENT_SHIFT       = 12;
  localparam int unsigned YEARS_PER_ERA    = 400;
  localparam int unsigned DAYS_PER_YEAR    = 365;
  localparam int unsigned DAYS_PER_ERA     = 146097;
  localparam int unsigned EPOCH_DAY_OFFSET = 719468;
  localparam int unsigned MAX_ERA          = 24;
  localparam int unsigned SEC_PER_DAY      = 86400;
  localparam int unsigned SEC_PER_HOUR     = 3600;
  localparam int unsigned SEC_PER_MIN      = 60;

  typedef enum logic [1:0] {
    ZK_NONE  = 2'd0,
    ZK_UTC   = 2'd1,
    ZK_PLUS  = 2'd2,
    ZK_MINUS = 2'd3
  } zone_kind_t;

  typedef enum logic [1:0] {
    ST_OK_ZONE   = 2'd0,
    ST_OK_LOCAL  = 2'd1,
    ST_FIELD_ERR = 2'd2,
    ST_ZONE_ERR  = 2'd3
  } status_t;

  // Decoded timestamp handed from the scanner to the arithmetic pipeline.
  typedef struct packed {
    status_t     status;
    zone_kind_t  zone;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  off_hours;
    logic [5:0]  off_minutes;
  } fields_t;

  // Day of the year counted from 1 March, for the first day of each month.
  function automatic logic [8:0] month_doy(input logic [3:0] month);
    logic [8:0] doy;
    case (month)
      4'd3:    doy = 9'd0;
      4'd4:    doy = 9'd31;
      4'd5:    doy = 9'd61;
      4'd6:    doy = 9'd92;
      4'd7:    doy = 9'd122;
      4'd8:    doy = 9'd153;
      4'd9:    doy = 9'd184;
      4'd10:   doy = 9'd214;
      4'd11:   doy = 9'd245;
      4'd12:   doy = 9'd275;
      4'd1:    doy = 9'd306;
      4'd2:    doy = 9'd337;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

### rtl/iso2ep_scan.sv
// ============================================================================
// iso2ep_scan - character scanner
// Collects date, time and zone digits one character per beat and, on the
// last character, registers the decoded fields with their status.
// ============================================================================
module iso2ep_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          char_code,
  input  logic                is_last,
  output logic                out_valid,
  input  logic                out_ready,
  output iso2ep_pkg::fields_t fields
);
  import iso2ep_pkg::*;

  logic [4:0]  pos, pos_next;
  logic [13:0] year_acc, year_next;
  logic [6:0]  month_acc, month_next;
  logic [6:0]  day_acc, day_next;
  logic [6:0]  hour_acc, hour_next;
  logic [6:0]  minute_acc, minute_next;
  logic [6:0]  second_acc, second_next;
  logic        digit_error, digit_error_next;
  zone_kind_t  zone_kind, zone_kind_next;
  logic [2:0]  zone_pos, zone_pos_next;
  logic [6:0]  off_hours_acc, off_hours_next;
  logic [6:0]  off_minutes_acc, off_minutes_next;
  logic        zone_error, zone_error_next;

  logic        accept;
  logic        is_digit;
  logic [3:0]  dval;
  logic        field_bad;
  logic        zone_bad;
  fields_t     snap;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dval     = 4'(char_code - CH_ZERO);

  always_comb begin
    pos_next         = pos;
    year_next        = year_acc;
    month_next       = month_acc;
    day_next         = day_acc;
    hour_next        = hour_acc;
    minute_next      = minute_acc;
    second_next      = second_acc;
    digit_error_next = digit_error;
    zone_kind_next   = zone_kind;
    zone_pos_next    = zone_pos;
    off_hours_next   = off_hours_acc;
    off_minutes_next = off_minutes_acc;
    zone_error_next  = zone_error;

    if (pos < 5'(DATE_LEN)) begin
      pos_next = pos + 5'd1;
      if (pos < 5'd4) begin
        if (is_digit) year_next = 14'(year_acc * 14'd10 + {10'd0, dval});
        else digit_error_next = 1'b1;
      end else if (pos inside {5'd5, 5'd6}) begin
        if (is_digit) month_next = 7'(month_acc * 7'd10 + {3'd0, dval});
        else digit_error_next = 1'b1;
      end else if (pos inside {5'd8, 5'd9}) begin
        if (is_digit) day_next = 7'(day_acc * 7'd10 + {3'd0, dval});
        else digit_error_next = 1'b1;
      end else if (pos inside {5'd11, 5'd12}) begin
        if (is_digit) hour_next = 7'(hour_acc * 7'd10 + {3'd0, dval});
        else digit_error_next = 1'b1;
      end else if (pos inside {5'd14, 5'd15}) begin
        if (is_digit) minute_next = 7'(minute_acc * 7'd10 + {3'd0, dval});
        else digit_error_next = 1'b1;
      end else if (pos inside {5'd17, 5'd18}) begin
        if (is_digit) second_next = 7'(second_acc * 7'd10 + {3'd0, dval});
        else digit_error_next = 1'b1;
      end
    end else if (zone_kind == ZK_NONE) begin
      if (char_code == CH_UTC) zone_kind_next = ZK_UTC;
      else if (char_code == CH_PLUS) zone_kind_next = ZK_PLUS;
      else if (char_code == CH_MINUS) zone_kind_next = ZK_MINUS;
    end else if (zone_kind != ZK_UTC && zone_pos < 3'(ZONE_FULL)) begin
      zone_pos_next = zone_pos + 3'd1;
      if (zone_pos < 3'd2) begin
        if (is_digit) off_hours_next = 7'(off_hours_acc * 7'd10 + {3'd0, dval});
        else zone_error_next = 1'b1;
      end else if (zone_pos == 3'd2) begin
        if (char_code != CH_COLON) zone_error_next = 1'b1;
      end else begin
        if (is_digit) off_minutes_next = 7'(off_minutes_acc * 7'd10 + {3'd0, dval});
        else zone_error_next = 1'b1;
      end
    end

    field_bad = (pos_next < 5'(DATE_LEN)) || digit_error_next ||
                (year_next < 14'(MIN_YEAR)) ||
                (month_next == 7'd0) || (month_next > 7'(MAX_MONTH)) ||
                (day_next == 7'd0) || (day_next > 7'(MAX_DAY)) ||
                (hour_next > 7'(MAX_HOUR)) || (minute_next > 7'(MAX_MINUTE)) ||
                (second_next > 7'(MAX_SECOND));
    zone_bad  = zone_error_next || (zone_pos_next < 3'(ZONE_FULL)) ||
                (off_hours_next > 7'(MAX_HOUR)) ||
                (off_minutes_next > 7'(MAX_MINUTE));

    if (field_bad) snap.status = ST_FIELD_ERR;
    else if (zone_kind_next == ZK_NONE) snap.status = ST_OK_LOCAL;
    else if (zone_kind_next == ZK_UTC) snap.status = ST_OK_ZONE;
    else if (zone_bad) snap.status = ST_ZONE_ERR;
    else snap.status = ST_OK_ZONE;

    // The narrow copies are only meaningful once the range checks pass.
    snap.zone        = zone_kind_next;
    snap.year        = year_next;
    snap.month       = month_next[3:0];
    snap.day         = day_next[4:0];
    snap.hour        = hour_next[4:0];
    snap.minute      = minute_next[5:0];
    snap.second      = second_next[5:0];
    snap.off_hours   = off_hours_next[4:0];
    snap.off_minutes = off_minutes_next[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos             <= 5'd0;
      year_acc        <= 14'd0;
      month_acc       <= 7'd0;
      day_acc         <= 7'd0;
      hour_acc        <= 7'd0;
      minute_acc      <= 7'd0;
      second_acc      <= 7'd0;
      digit_error     <= 1'b0;
      zone_kind       <= ZK_NONE;
      zone_pos        <= 3'd0;
      off_hours_acc   <= 7'd0;
      off_minutes_acc <= 7'd0;
      zone_error      <= 1'b0;
    end else if (accept && is_last) begin
      pos             <= 5'd0;
      year_acc        <= 14'd0;
      month_acc       <= 7'd0;
      day_acc         <= 7'd0;
      hour_acc        <= 7'd0;
      minute_acc      <= 7'd0;
      second_acc      <= 7'd0;
      digit_error     <= 1'b0;
      zone_kind       <= ZK_NONE;
      zone_pos        <= 3'd0;
      off_hours_acc   <= 7'd0;
      off_minutes_acc <= 7'd0;
      zone_error      <= 1'b0;
    end else if (accept) begin
      pos             <= pos_next;
      year_acc        <= year_next;
      month_acc       <= month_next;
      day_acc         <= day_next;
      hour_acc        <= hour_next;
      minute_acc      <= minute_next;
      second_acc      <= second_next;
      digit_error     <= digit_error_next;
      zone_kind       <= zone_kind_next;
      zone_pos        <= zone_pos_next;
      off_hours_acc   <= off_hours_next;
      off_minutes_acc <= off_minutes_next;
      zone_error      <= zone_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      fields <= snap;
    end
  end

`ifndef SYNTHESIS
  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    pos <= 5'(DATE_LEN))
    else $error("character position ran past the date length");

  a_zone_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    zone_pos <= 3'(ZONE_FULL))
    else $error("zone position ran past the full offset length");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> (pos == 5'd0) && (zone_kind == ZK_NONE) && !digit_error)
    else $error("scanner state not cleared after the last character");
`endif

endmodule

### rtl/iso2ep_calc.sv
// ============================================================================
// iso2ep_calc - calendar arithmetic pipeline
// Turns the decoded fields into Unix seconds through the days-from-civil
// rule, with its constant multiplications spread over the register stages.
// ============================================================================
module iso2ep_calc (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iso2ep_pkg::fields_t fields,
  input  logic signed [17:0]  local_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [38:0]         epoch,
  output iso2ep_pkg::status_t status
);
  import iso2ep_pkg::*;

  logic adv2, adv3, adv4, adv5, adv6;
  logic v2, v3, v4, v5;

  // Stage 2: era, time of day with zone correction, day of the year.
  logic [13:0]        yadj;
  logic [25:0]        era_prod;
  logic [16:0]        tod, off;
  logic signed [18:0] adj, tod_adj;
  status_t            s2_status;
  logic [13:0]        s2_year;
  logic [4:0]         s2_era;
  logic [8:0]         s2_doy;
  logic signed [18:0] s2_tod;

  // Stage 3: year of the era.
  logic [13:0]        era400, yoe_full;
  status_t            s3_status;
  logic [4:0]         s3_era;
  logic [8:0]         s3_yoe;
  logic [8:0]         s3_doy;
  logic signed [18:0] s3_tod;

  // Stage 4: day of the era.
  logic [13:0]        cent_prod;
  logic [17:0]        doe;
  status_t            s4_status;
  logic [4:0]         s4_era;
  logic [17:0]        s4_doe;
  logic signed [18:0] s4_tod;

  // Stage 5: days since 1970-01-01.
  logic [22:0]        days;
  status_t            s5_status;
  logic signed [22:0] s5_days;
  logic signed [18:0] s5_tod;

  logic [38:0]        epoch_val;
  logic               s5_ok;

  assign adv6     = !out_valid || out_ready;
  assign adv5     = !v5 || adv6;
  assign adv4     = !v4 || adv5;
  assign adv3     = !v3 || adv4;
  assign adv2     = !v2 || adv3;
  assign in_ready = adv2;

  always_comb begin
    yadj     = (fields.month <= 4'd2) ? fields.year - 14'd1 : fields.year;
    era_prod = 26'(yadj) * 26'(ERA_RECIP);
    tod      = 17'(fields.hour) * 17'(SEC_PER_HOUR) + 17'(fields.minute) * 17'(SEC_PER_MIN)
             + 17'(fields.second);
    off      = 17'(fields.off_hours) * 17'(SEC_PER_HOUR)
             + 17'(fields.off_minutes) * 17'(SEC_PER_MIN);
    case (fields.zone)
      ZK_NONE:  adj = -$signed({local_offset[17], local_offset});
      ZK_UTC:   adj = 19'sd0;
      ZK_PLUS:  adj = -$signed({2'b00, off});
      ZK_MINUS: adj = $signed({2'b00, off});
      default:  adj = 19'sd0;
    endcase
    tod_adj  = $signed({2'b00, tod}) + adj;
  end

  assign era400    = 14'(s2_era) * 14'(YEARS_PER_ERA);
  assign yoe_full  = s2_year - era400;
  assign cent_prod = 14'(s3_yoe) * 14'(CENT_RECIP);
  assign doe       = 18'(s3_yoe) * 18'(DAYS_PER_YEAR) + 18'(s3_yoe >> 2)
                   - 18'(cent_prod >> CENT_SHIFT) + 18'(s3_doy);
  assign days      = 23'(s4_era) * 23'(DAYS_PER_ERA) + 23'(s4_doe) - 23'(EPOCH_DAY_OFFSET);
  assign s5_ok     = (s5_status == ST_OK_ZONE) || (s5_status == ST_OK_LOCAL);
  assign epoch_val = 39'({{16{s5_days[22]}}, s5_days}) * 39'(SEC_PER_DAY)
                   + 39'({{20{s5_tod[18]}}, s5_tod});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv2) v2 <= in_valid;
      if (adv3) v3 <= v2;
      if (adv4) v4 <= v3;
      if (adv5) v5 <= v4;
      if (adv6) out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_status <= fields.status;
      s2_year   <= yadj;
      s2_era    <= 5'(era_prod >> ERA_SHIFT);
      s2_doy    <= 9'(month_doy(fields.month) + 9'(fields.day) - 9'd1);
      s2_tod    <= tod_adj;
    end
    if (adv3) begin
      s3_status <= s2_status;
      s3_era    <= s2_era;
      s3_yoe    <= yoe_full[8:0];
      s3_doy    <= s2_doy;
      s3_tod    <= s2_tod;
    end
    if (adv4) begin
      s4_status <= s3_status;
      s4_era    <= s3_era;
      s4_doe    <= doe;
      s4_tod    <= s3_tod;
    end
    if (adv5) begin
      s5_status <= s4_status;
      s5_days   <= $signed(days);
      s5_tod    <= s4_tod;
    end
    if (adv6) begin
      status <= s5_status;
      epoch  <= s5_ok ? epoch_val : 39'd0;
    end
  end

`ifndef SYNTHESIS
  a_era_range: assert property (@(posedge clk) disable iff (rst)
    (v2 && (s2_status == ST_OK_ZONE || s2_status == ST_OK_LOCAL))
      |-> (s2_era <= 5'(MAX_ERA)))
    else $error("era out of range for a valid year");

  a_yoe_range: assert property (@(posedge clk) disable iff (rst)
    (v3 && (s3_status == ST_OK_ZONE || s3_status == ST_OK_LOCAL))
      |-> (s3_yoe < 9'(YEARS_PER_ERA)))
    else $error("year of era not below 400: reciprocal division slipped");

  a_doe_range: assert property (@(posedge clk) disable iff (rst)
    (v4 && (s4_status == ST_OK_ZONE || s4_status == ST_OK_LOCAL))
      |-> (s4_doe < 18'(DAYS_PER_ERA + 367)))
    else $error("day of era out of range");
`endif

endmodule

### rtl/iso8601_timestamp_to_epoch.sv
// ============================================================================
// iso8601_timestamp_to_epoch - ISO 8601 timestamp text to Unix seconds
// Scans YYYY-MM-DDThh:mm:ss with an optional Z or +-hh:mm zone, one character
// per beat, and returns Unix seconds with a status on the last character.
// ============================================================================
// Throughput: one character per clock cycle, back to back, on the input stream,
// unless the scanner's result register is full and stalled. Result path: the
// scanner register takes the decoded fields at the edge that accepts the last
// character, then five calendar arithmetic register stages follow.
// Reset: synchronous, active high; it clears the scanner, empties the pipeline
// and sets the local offset register to zero. No clearing pass is needed.
module iso8601_timestamp_to_epoch (
  input  logic        clk,
  input  logic        rst,
  // Timestamp characters.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // is_last
  // Results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [38:0] epoch_seconds (signed), [39] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // Local offset register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [17:0] cfg_data   // [17:0] local_offset_seconds (signed)
);
  import iso2ep_pkg::*;

  // Local clock offset east of UTC, applied only when the text has no zone.
  // Writes are always taken; the user must keep the block idle whenever one arrives (not enforced here).
  logic signed [17:0] local_offset;

  fields_t     scan_fields;
  logic        scan_valid;
  logic        calc_ready;
  logic [38:0] epoch;
  status_t     status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_offset <= 18'sd0;
    end else if (cfg_valid && cfg_ready) begin
      local_offset <= $signed(cfg_data);
    end
  end

  // The scanner owns the running accumulators and registers one decoded
  // timestamp per last character. Characters that are not last never wait
  // on the pipeline unless the hand-over register itself is full and stalled.
  iso2ep_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .char_code (s_tdata),
    .is_last   (s_tlast),
    .out_valid (scan_valid),
    .out_ready (calc_ready),
    .fields    (scan_fields)
  );

  // The arithmetic pipeline has a valid bit per stage and collapses bubbles,
  // so a stalled result at the output holds only the stages behind it.
  iso2ep_calc u_calc (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (scan_valid),
    .in_ready     (calc_ready),
    .fields       (scan_fields),
    .local_offset (local_offset),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .epoch        (epoch),
    .status       (status)
  );

  assign m_tdata = {1'b0, epoch};
  assign m_tuser = status;

endmodule

### dv/tb_top.sv
// ============================================================================
// tb_top - self-checking bench for the timestamp-to-epoch converter
// Streams timestamp texts into the block one character per beat, predicts the
// Unix seconds and status of every text, and compares each result beat with
// the oldest prediction. A table of hand-picked texts comes first, followed by
// phases of random texts under different local offset settings.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iso2ep_pkg::*;

  // Separator handling for the directed table. When bit 8 is set, the
  // separators at indexes 4, 7, 10, 13 and 16 are replaced by bits 7:0.
  localparam logic [8:0] KEEP_SEPS = 9'h000;
  localparam logic [8:0] ZERO_SEPS = 9'h100;
  localparam logic [8:0] HIGH_SEPS = 9'h1FF;

  localparam int TARGET_CHARS = 1950;
  localparam int TEXTS_PER_PHASE = 12;
  localparam int DRAIN_CYCLES = 10;

  // One expected result beat.
  typedef struct packed {
    logic [38:0] epoch;
    status_t     status;
  } epoch_result_t;

  // One row of the directed table.
  typedef struct {
    string      text;
    logic [8:0] seps;
    bit         typed;
    longint     epoch;
    status_t    status;
  } text_case_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [17:0] cfg_data;

  iso8601_timestamp_to_epoch uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Predicted results still waiting for their beat on the output stream.
  epoch_result_t pending_epochs[$];
  int error_count = 0;
  int sent_chars = 0;
  // When set, neither side inserts idle cycles.
  bit calm = 1'b0;

  // --------------------------------------------------------------------------
  // Converter state as the bench sees it. It mirrors the scanner: the digit
  // accumulators of the date and time, the zone marker and its offset digits,
  // and the local offset register.
  // --------------------------------------------------------------------------
  logic [4:0]         scan_pos;
  logic [13:0]        year_sum;
  logic [6:0]         month_sum, day_sum, hour_sum, minute_sum, second_sum;
  bit                 date_bad;
  zone_kind_t         zone_seen;
  logic [2:0]         zone_pos;
  logic [6:0]         zone_hours, zone_minutes;
  bit                 zone_bad;
  logic signed [17:0] local_offset;

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Appends one decimal digit to an accumulator; a non-digit leaves it as is.
  function automatic logic [13:0] add_digit(logic [13:0] acc, logic [7:0] c);
    return is_digit(c) ? acc * 14'd10 + 14'(c - CH_ZERO) : acc;
  endfunction

  function automatic void clear_scan();
    scan_pos = '0;
    year_sum = '0;
    month_sum = '0;
    day_sum = '0;
    hour_sum = '0;
    minute_sum = '0;
    second_sum = '0;
    date_bad = 1'b0;
    zone_seen = ZK_NONE;
    zone_pos = '0;
    zone_hours = '0;
    zone_minutes = '0;
    zone_bad = 1'b0;
  endfunction

  // Days since 1970-01-01 of a proleptic Gregorian date, counting the year
  // from 1 March so that the leap day falls at its end.
  function automatic longint civil_days(longint y, longint m, longint d);
    longint era, yoe, mp, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / longint'(YEARS_PER_ERA);
    yoe = y - era * longint'(YEARS_PER_ERA);
    mp = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * longint'(DAYS_PER_YEAR) + yoe / 4 - yoe / 100 + doy;
    return era * longint'(DAYS_PER_ERA) + doe - longint'(EPOCH_DAY_OFFSET);
  endfunction

  // Takes one accepted character. Returns 1 with the result when the
  // character closes the text.
  function automatic bit scan_char(input logic [7:0] c, input bit last,
                                   output epoch_result_t res);
    longint wall, off, secs;
    status_t st;
    if (scan_pos < DATE_LEN) begin
      case (scan_pos)
        5'd0, 5'd1, 5'd2, 5'd3: year_sum = add_digit(year_sum, c);
        5'd5, 5'd6:   month_sum = 7'(add_digit(14'(month_sum), c));
        5'd8, 5'd9:   day_sum = 7'(add_digit(14'(day_sum), c));
        5'd11, 5'd12: hour_sum = 7'(add_digit(14'(hour_sum), c));
        5'd14, 5'd15: minute_sum = 7'(add_digit(14'(minute_sum), c));
        5'd17, 5'd18: second_sum = 7'(add_digit(14'(second_sum), c));
        default: ;
      endcase
      // Separator positions are never checked.
      if (!(scan_pos inside {5'd4, 5'd7, 5'd10, 5'd13, 5'd16}) && !is_digit(c))
        date_bad = 1'b1;
      scan_pos = scan_pos + 5'd1;
    end else if (zone_seen == ZK_NONE) begin
      if (c == CH_UTC) zone_seen = ZK_UTC;
      else if (c == CH_PLUS) zone_seen = ZK_PLUS;
      else if (c == CH_MINUS) zone_seen = ZK_MINUS;
    end else if (zone_seen != ZK_UTC && zone_pos < ZONE_FULL) begin
      if (zone_pos < 3'd2) begin
        zone_hours = 7'(add_digit(14'(zone_hours), c));
        if (!is_digit(c)) zone_bad = 1'b1;
      end else if (zone_pos == 3'd2) begin
        if (c != CH_COLON) zone_bad = 1'b1;
      end else begin
        zone_minutes = 7'(add_digit(14'(zone_minutes), c));
        if (!is_digit(c)) zone_bad = 1'b1;
      end
      zone_pos = zone_pos + 3'd1;
    end

    if (!last) return 1'b0;

    secs = 0;
    if (scan_pos < DATE_LEN || date_bad || year_sum < MIN_YEAR ||
        month_sum < 1 || month_sum > MAX_MONTH || day_sum < 1 || day_sum > MAX_DAY ||
        hour_sum > MAX_HOUR || minute_sum > MAX_MINUTE || second_sum > MAX_SECOND) begin
      st = ST_FIELD_ERR;
    end else begin
      wall = civil_days(longint'(year_sum), longint'(month_sum), longint'(day_sum))
             * longint'(SEC_PER_DAY) + longint'(hour_sum) * longint'(SEC_PER_HOUR)
             + longint'(minute_sum) * longint'(SEC_PER_MIN) + longint'(second_sum);
      if (zone_seen == ZK_NONE) begin
        secs = wall - longint'(local_offset);
        st = ST_OK_LOCAL;
      end else if (zone_seen == ZK_UTC) begin
        secs = wall;
        st = ST_OK_ZONE;
      end else if (zone_bad || zone_pos < ZONE_FULL ||
                   zone_hours > MAX_HOUR || zone_minutes > MAX_MINUTE) begin
        st = ST_ZONE_ERR;
      end else begin
        off = longint'(zone_hours) * longint'(SEC_PER_HOUR)
              + longint'(zone_minutes) * longint'(SEC_PER_MIN);
        secs = (zone_seen == ZK_PLUS) ? wall - off : wall + off;
        st = ST_OK_ZONE;
      end
    end
    res.epoch = secs[38:0];
    res.status = st;
    clear_scan();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Directed texts. Expected values are typed in where they are obvious: the
  // epoch itself, the local offset after reset, one round-number epoch, and
  // every error status. The remaining rows are checked by the predictor.
  // --------------------------------------------------------------------------
  text_case_t text_cases [25] = '{
    '{"1970-01-01T00:00:00Z",          KEEP_SEPS, 1'b1, 0, ST_OK_ZONE},
    '{"1970-01-01T00:00:00",           KEEP_SEPS, 1'b1, 0, ST_OK_LOCAL},
    '{"9999-12-31T23:59:60-23:59",     KEEP_SEPS, 1'b0, 0, ST_OK_ZONE},
    '{"9999-12-31T23:59:59Z",          KEEP_SEPS, 1'b0, 0, ST_OK_ZONE},
    '{"2000-02-29T12:34:56+05:30",     KEEP_SEPS, 1'b0, 0, ST_OK_ZONE},
    '{"2021-02-31T07:08:09+00:00",     KEEP_SEPS, 1'b0, 0, ST_OK_ZONE},
    '{"2001-09-09T01:46:40Z",          ZERO_SEPS, 1'b1, 1000000000, ST_OK_ZONE},
    '{"1999-12-31T23:59:59Z",          HIGH_SEPS, 1'b0, 0, ST_OK_ZONE},
    '{"2010-06-15T08:00:00ab+02:00xyz", KEEP_SEPS, 1'b0, 0, ST_OK_ZONE},
    '{"2010-06-15T08:00:00Z+01:00",    KEEP_SEPS, 1'b0, 0, ST_OK_ZONE},
    '{"1969-12-31T23:59:59Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-00-01T00:00:00Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-13-01T00:00:00Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-01-00T00:00:00Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-01-32T00:00:00Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-01-01T24:00:00Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-01-01T00:60:00Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-01-01T00:00:61Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"19x0-01-01T00:00:00Z",          KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-01-01T00:00",              KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"7",                             KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR},
    '{"1970-01-01T00:00:00+01",        KEEP_SEPS, 1'b1, 0, ST_ZONE_ERR},
    '{"1970-01-01T00:00:00+01-00",     KEEP_SEPS, 1'b1, 0, ST_ZONE_ERR},
    '{"1970-01-01T00:00:00+24:00",     KEEP_SEPS, 1'b1, 0, ST_ZONE_ERR},
    '{"1969-01-01T00:00:00+0",         KEEP_SEPS, 1'b1, 0, ST_FIELD_ERR}
  };

  // Local offset settings for the first random phases: both limits of the
  // legal range, both limits of the 18-bit register, and zero. Later phases
  // draw the whole register at random.
  logic [17:0] offset_presets [5] = '{
    18'd86399, 18'(-86399), 18'h1FFFF, 18'h20000, 18'd0
  };

  // The text currently being sent, one character per entry.
  logic [7:0] text_buf[$];

  // Sends one character beat and records the prediction once it is accepted.
  // The valid is lowered only when a gap follows, so that a back-to-back beat
  // never sees valid dropped and raised within the same time step.
  task automatic send_char(input logic [7:0] c, input bit last, input bit typed,
                           input longint t_epoch, input status_t t_status);
    int gap;
    epoch_result_t res;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sent_chars++;
    if (scan_char(c, last, res)) begin
      if (typed) begin
        res.epoch = t_epoch[38:0];
        res.status = t_status;
      end
      pending_epochs.push_back(res);
    end
  endtask

  task automatic send_text(input bit typed, input longint t_epoch,
                           input status_t t_status);
    foreach (text_buf[i])
      send_char(text_buf[i], i == text_buf.size() - 1, typed, t_epoch, t_status);
  endtask

  // Holds the input side until every predicted result has been seen.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk);
    // A short idle spell before whatever follows.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the local offset register. Only called while the block is idle.
  task automatic set_local_offset(input logic [17:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    local_offset = value;
  endtask

  function automatic void put_number(int value, int digits);
    int div;
    div = 1;
    repeat (digits - 1) div = div * 10;
    repeat (digits) begin
      text_buf.push_back(CH_ZERO + 8'((value / div) % 10));
      div = div / 10;
    end
  endfunction

  // A separator that is usually the expected character and now and then any
  // byte at all, since separators are not checked.
  function automatic logic [7:0] pick_sep(logic [7:0] usual);
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : usual;
  endfunction

  // Builds a random text. Most texts are well formed with random content; the
  // rest carry one flaw: a field out of range, a stray byte, a text cut short,
  // a zone offset out of range, or a broken zone form.
  task automatic build_random_text();
    int yr, mo, dy, hr, mi, se, oh, om, zsel, flaw, keep, spot;
    yr = $urandom_range(1970, 9999);
    mo = $urandom_range(1, 12);
    dy = $urandom_range(1, 31);
    hr = $urandom_range(0, 23);
    mi = $urandom_range(0, 59);
    se = $urandom_range(0, 60);
    oh = $urandom_range(0, 23);
    om = $urandom_range(0, 59);
    zsel = $urandom_range(0, 3);
    flaw = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 5);
    if (flaw == 1) begin
      case ($urandom_range(0, 5))
        0: yr = $urandom_range(0, 1969);
        1: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
        2: dy = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
        3: hr = $urandom_range(24, 99);
        4: mi = $urandom_range(60, 99);
        default: se = $urandom_range(61, 99);
      endcase
    end
    if (flaw >= 4) begin
      zsel = $urandom_range(2, 3);
      if (flaw == 4) begin
        if ($urandom_range(0, 1)) oh = $urandom_range(24, 99);
        else om = $urandom_range(60, 99);
      end
    end

    text_buf = {};
    put_number(yr, 4);
    text_buf.push_back(pick_sep(CH_MINUS));
    put_number(mo, 2);
    text_buf.push_back(pick_sep(CH_MINUS));
    put_number(dy, 2);
    text_buf.push_back(pick_sep(8'h54));
    put_number(hr, 2);
    text_buf.push_back(pick_sep(CH_COLON));
    put_number(mi, 2);
    text_buf.push_back(pick_sep(CH_COLON));
    put_number(se, 2);
    // Now and then some lower-case filler before the zone marker.
    if (zsel != 0 && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) text_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
    if (zsel == 1) begin
      text_buf.push_back(CH_UTC);
    end else if (zsel >= 2) begin
      text_buf.push_back(zsel == 2 ? CH_PLUS : CH_MINUS);
      put_number(oh, 2);
      text_buf.push_back(flaw == 5 && $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                         : CH_COLON);
      put_number(om, 2);
    end
    if (zsel != 0)
      repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(0, 255)));

    if (flaw == 2) begin
      spot = $urandom_range(0, text_buf.size() - 1);
      text_buf[spot] = 8'($urandom_range(0, 255));
    end else if (flaw == 3) begin
      keep = $urandom_range(1, text_buf.size() - 1);
      while (text_buf.size() > keep) void'(text_buf.pop_back());
    end else if (flaw == 5 && $urandom_range(0, 1)) begin
      // Cut inside the zone offset.
      keep = $urandom_range(DATE_LEN + 1, text_buf.size() - 1);
      while (text_buf.size() > keep) void'(text_buf.pop_back());
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random back-pressure and the comparison of every result
  // beat with the oldest prediction.
  // --------------------------------------------------------------------------
  int rx_hold = 0;

  always @(posedge clk) begin : result_check
    epoch_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_epochs.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat, actual epoch %0d status %0d",
                   $time, $signed(m_tdata[38:0]), m_tuser);
        end else begin
          want = pending_epochs.pop_front();
          if (want.epoch != m_tdata[38:0]) begin
            error_count++;
            $display("%0t: epoch_seconds mismatch, expected %0d, actual %0d",
                     $time, $signed(want.epoch), $signed(m_tdata[38:0]));
          end
          if (want.status != status_t'(m_tuser)) begin
            error_count++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, m_tuser);
          end
        end
        rx_hold = calm ? 0 : $urandom_range(0, 5);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      m_tready <= (rx_hold == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then phases of random texts,
  // each opened by a new local offset setting written while the block idles.
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int phase;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    local_offset = '0;
    clear_scan();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (text_cases[i]) begin
      text_buf = {};
      for (int j = 0; j < text_cases[i].text.len(); j++)
        text_buf.push_back(text_cases[i].text[j]);
      if (text_cases[i].seps[8]) begin
        foreach (text_buf[j])
          if (j inside {4, 7, 10, 13, 16}) text_buf[j] = text_cases[i].seps[7:0];
      end
      send_text(text_cases[i].typed, text_cases[i].epoch, text_cases[i].status);
    end

    phase = 0;
    while (sent_chars < TARGET_CHARS) begin
      set_local_offset(phase < 5 ? offset_presets[phase] : 18'($urandom));
      // Every fourth phase runs with no idle cycles on either side.
      calm = (phase % 4 == 3);
      repeat (TEXTS_PER_PHASE) begin
        if (sent_chars < TARGET_CHARS) begin
          build_random_text();
          send_text(1'b0, 0, ST_OK_ZONE);
        end
      end
      phase++;
    end

    drain_results();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake; several times the slowest correct run.
  initial begin : watchdog
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
rtl/iso2ep_pkg.sv
rtl/iso2ep_scan.sv
rtl/iso2ep_calc.sv
rtl/iso8601_timestamp_to_epoch.sv
dv/tb_top.sv
